/* src/spe_pkg.sv */
package spe_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       paragraph_end;
    } out_item_t;

    typedef enum logic [2:0] {
        MODE_SKIP     = 3'd0,
        MODE_COMMENT  = 3'd1,
        MODE_PARA     = 3'd2,
        MODE_AFTER_LF = 3'd3,
        MODE_DISCARD  = 3'd4
    } mode_t;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_NUL  = 8'h00;

endpackage

/* src/stanza_paragraph_extractor.sv */
// Channel   Ports                          Payload
// input     s_valid, s_ready, s_data       spe_pkg::in_item_t  (in_byte, in_last)
// result    m_valid, m_ready, m_data       spe_pkg::out_item_t (out_byte, has_byte,
//                                          paragraph_end)
// config    cfg_valid, cfg_ready, cfg_data comments_allowed, 1 bit
//
// One byte is accepted per cycle when the result side keeps up; the mode update
// for each byte is a single step of short logic between the input register and
// the result register.
// A byte's result, if it has one, passes from the input register into the result
// register once the result register is free, and is offered from there.
// Synchronous active-low reset returns to skipping leading whitespace with
// comments disabled.
// A stalled result holds in the result register while one more byte waits in
// the input register; the configuration port is always ready.
module stanza_paragraph_extractor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spe_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output spe_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    logic               in_valid_reg;
    spe_pkg::in_item_t  in_reg;
    logic               out_valid_reg;
    spe_pkg::out_item_t out_reg;
    spe_pkg::mode_t     mode_reg;
    spe_pkg::mode_t     mode_step;
    spe_pkg::mode_t     mode_next;
    logic               comments_reg;
    logic               advance;
    logic               emit;
    logic               end_flag;
    logic               is_blank;
    spe_pkg::out_item_t out_next;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign is_blank = (in_reg.in_byte == spe_pkg::CH_SP) || (in_reg.in_byte == spe_pkg::CH_TAB)
                   || (in_reg.in_byte == spe_pkg::CH_CR) || (in_reg.in_byte == spe_pkg::CH_LF);

    // Next state: first the byte itself, then the last flag closes the buffer.
    always_comb begin
        mode_step = mode_reg;
        unique case (mode_reg)
            spe_pkg::MODE_COMMENT: begin
                if (in_reg.in_byte == spe_pkg::CH_LF) begin
                    mode_step = spe_pkg::MODE_SKIP;
                end
            end
            spe_pkg::MODE_PARA: begin
                if (in_reg.in_byte == spe_pkg::CH_NUL) begin
                    mode_step = spe_pkg::MODE_DISCARD;
                end else if (in_reg.in_byte == spe_pkg::CH_LF) begin
                    mode_step = spe_pkg::MODE_AFTER_LF;
                end
            end
            spe_pkg::MODE_AFTER_LF: begin
                if (in_reg.in_byte == spe_pkg::CH_NUL) begin
                    mode_step = spe_pkg::MODE_DISCARD;
                end else if (in_reg.in_byte == spe_pkg::CH_LF) begin
                    mode_step = spe_pkg::MODE_SKIP;
                end else if (in_reg.in_byte != spe_pkg::CH_CR) begin
                    mode_step = spe_pkg::MODE_PARA;
                end
            end
            spe_pkg::MODE_DISCARD: begin
                mode_step = spe_pkg::MODE_DISCARD;
            end
            default: begin
                if (in_reg.in_byte == spe_pkg::CH_NUL) begin
                    mode_step = spe_pkg::MODE_DISCARD;
                end else if (is_blank) begin
                    mode_step = spe_pkg::MODE_SKIP;
                end else if (in_reg.in_byte == spe_pkg::CH_HASH && comments_reg) begin
                    mode_step = spe_pkg::MODE_COMMENT;
                end else begin
                    mode_step = spe_pkg::MODE_PARA;
                end
            end
        endcase
        mode_next = in_reg.in_last ? spe_pkg::MODE_SKIP : mode_step;
    end

    // Outputs: which bytes pass through and where a paragraph closes.
    always_comb begin
        emit     = 1'b0;
        end_flag = 1'b0;
        unique case (mode_reg)
            spe_pkg::MODE_COMMENT: begin
                emit = 1'b0;
            end
            spe_pkg::MODE_PARA: begin
                if (in_reg.in_byte == spe_pkg::CH_NUL) begin
                    end_flag = 1'b1;
                end else if (in_reg.in_byte != spe_pkg::CH_CR) begin
                    emit = 1'b1;
                end
            end
            spe_pkg::MODE_AFTER_LF: begin
                if (in_reg.in_byte == spe_pkg::CH_NUL || in_reg.in_byte == spe_pkg::CH_LF) begin
                    end_flag = 1'b1;
                end else if (in_reg.in_byte != spe_pkg::CH_CR) begin
                    emit = 1'b1;
                end
            end
            spe_pkg::MODE_DISCARD: begin
                emit = 1'b0;
            end
            default: begin
                emit = (in_reg.in_byte != spe_pkg::CH_NUL) && !is_blank
                    && !(in_reg.in_byte == spe_pkg::CH_HASH && comments_reg);
            end
        endcase
        // The last byte of a buffer closes a paragraph that is still open.
        if (in_reg.in_last
            && (mode_step == spe_pkg::MODE_PARA || mode_step == spe_pkg::MODE_AFTER_LF)) begin
            end_flag = 1'b1;
        end
        out_next.out_byte      = emit ? in_reg.in_byte : 8'd0;
        out_next.has_byte      = emit;
        out_next.paragraph_end = end_flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= spe_pkg::MODE_SKIP;
            comments_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= emit || end_flag;
                mode_reg      <= mode_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                comments_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.has_byte || m_data.paragraph_end))
        else $error("result transfer carries neither a byte nor an end");

    a_zero_without_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.has_byte) |-> (m_data.out_byte == 8'd0))
        else $error("out_byte is not zero without a byte");

    a_last_resets_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.in_last) |=> (mode_reg == spe_pkg::MODE_SKIP))
        else $error("last byte did not return to skipping whitespace");

    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("waiting input byte was lost or changed");

endmodule
